FILE: design/smx_pkg.sv
// Shared widths, constants and the exp2 table for the softmax core.
`default_nettype none

package smx_pkg;

    localparam int LOGIT_W = 16;
    localparam int E_W     = 17;
    localparam int PROB_W  = 16;
    localparam int CLASS_W = 3;

    // exp value of the maximum logit, 1.0 in Q1.16
    localparam logic [E_W-1:0] E_ONE     = 17'd65536;
    // log2(e) in Q16
    localparam logic [E_W-1:0] LOG2E_Q16 = 17'd94548;
    // ln2/256 in Q16
    localparam logic [E_W-1:0] LN2_Q16   = 17'd177;

    // round(65536 * 2^(-i/16))
    localparam logic [E_W-1:0] EXP2_TAB [16] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549,
        17'd55109, 17'd52773, 17'd50535, 17'd48393,
        17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219
    };

endpackage

`default_nettype wire

FILE: design/softmax_probabilities_core.sv
// Softmax core: logit store, exp pass into an exp store, then per-class division.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_logit, i_last_logit
//  out     | output    | o_out_valid / i_out_ready | o_class_index, o_probability,
//          |           |                           | o_last_class, o_dropped_logits
//
// Logits load at one per cycle. A closing transfer starts the exp pass over the stored
// logits through the three-stage exp pipeline; then each class goes through the 17-step
// divider and waits out any output stall. Input is held off from the closing transfer
// until the last result sits in the output register. Synchronous active-low reset
// clears control; the stores need no clearing. While the output register is stalled
// the divider holds its result.
`default_nettype none

module softmax_probabilities_core #(
    parameter int MAX_CLASSES = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [smx_pkg::LOGIT_W-1:0]    i_logit,
    input  wire logic                           i_last_logit,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [smx_pkg::CLASS_W-1:0]         o_class_index,
    output logic [smx_pkg::PROB_W-1:0]          o_probability,
    output logic                                o_last_class,
    output logic                                o_dropped_logits
);
    import smx_pkg::*;

    localparam int CNT_W = $clog2(MAX_CLASSES + 1);
    localparam int IDX_W = $clog2(MAX_CLASSES);
    localparam int SUM_W = E_W + $clog2(MAX_CLASSES);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_EXP  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;

    // stores
    logic [LOGIT_W-1:0] r_logit_mem [MAX_CLASSES];
    logic [E_W-1:0]     r_exp_mem   [MAX_CLASSES];
    logic [LOGIT_W-1:0] r_logit_q;
    logic [E_W-1:0]     r_exp_q;

    // run state
    logic [2:0]         r_state,   n_state;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic [LOGIT_W-1:0] r_max,     n_max;
    logic               r_ovf,     n_ovf;
    logic [SUM_W-1:0]   r_sum,     n_sum;
    logic [CNT_W-1:0]   r_rd_idx,  n_rd_idx;
    logic               r_rd_vld,  n_rd_vld;
    logic [CNT_W-1:0]   r_wr_idx,  n_wr_idx;
    logic [IDX_W-1:0]   r_idx,     n_idx;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [CLASS_W-1:0] r_out_idx;
    logic [PROB_W-1:0]  r_out_prob;
    logic               r_out_last;
    logic               r_out_drop;

    logic               in_xfer;
    logic               room;
    logic               logit_we;
    logic               logit_re;
    logic               exp_re;
    logic [16:0]        diff;
    logic               exp_valid;
    logic [E_W-1:0]     exp_e;
    logic               div_start;
    logic               div_done;
    logic [PROB_W-1:0]  div_prob;
    logic               out_free;
    logic               out_load;
    logic               last_elem;
    logic [IDX_W+CLASS_W-1:0] idx_wide;

    assign o_in_ready = (r_state == S_LOAD);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign room       = r_count < CNT_W'(MAX_CLASSES);
    assign logit_we   = in_xfer && room;
    assign logit_re   = (r_state == S_EXP) && (r_rd_idx < r_count);
    assign exp_re     = (r_state == S_RD);
    assign div_start  = (r_state == S_DIV);
    assign out_free   = !r_out_valid || i_out_ready;
    assign out_load   = (r_state == S_WAIT) && div_done && out_free;
    assign last_elem  = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    assign idx_wide   = (IDX_W + CLASS_W)'(r_idx);

    // distance below the running maximum, always 0..65535
    assign diff = {r_max[LOGIT_W-1], r_max} - {r_logit_q[LOGIT_W-1], r_logit_q};

    smx_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_vld),
        .i_u     (diff[15:0]),
        .o_valid (exp_valid),
        .o_e     (exp_e)
    );

    smx_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_e     (r_exp_q),
        .i_sum   (r_sum),
        .o_done  (div_done),
        .o_prob  (div_prob)
    );

    // logit store: written while loading, read during the exp pass only
    always_ff @(posedge i_clk) begin
        if (logit_we) begin
            r_logit_mem[r_count[IDX_W-1:0]] <= i_logit;
        end
        if (logit_re) begin
            r_logit_q <= r_logit_mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    // exp store: written by the exp pass, read once the pass has finished
    always_ff @(posedge i_clk) begin
        if (exp_valid) begin
            r_exp_mem[r_wr_idx[IDX_W-1:0]] <= exp_e;
        end
        if (exp_re) begin
            r_exp_q <= r_exp_mem[r_idx];
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_max    = r_max;
        n_ovf    = r_ovf;
        n_sum    = r_sum;
        n_rd_idx = r_rd_idx;
        n_rd_vld = logit_re;
        n_wr_idx = r_wr_idx;
        n_idx    = r_idx;
        unique case (r_state)
            S_LOAD: begin
                if (in_xfer) begin
                    if (room) begin
                        n_count = r_count + CNT_W'(1);
                        if ($signed(i_logit) > $signed(r_max)) begin
                            n_max = i_logit;
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_logit) begin
                        n_state  = S_EXP;
                        n_rd_idx = '0;
                        n_wr_idx = '0;
                        n_sum    = '0;
                    end
                end
            end
            S_EXP: begin
                if (logit_re) begin
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end
                if (exp_valid) begin
                    n_sum    = r_sum + SUM_W'(exp_e);
                    n_wr_idx = r_wr_idx + CNT_W'(1);
                    if ((r_wr_idx + CNT_W'(1)) == r_count) begin
                        n_state = S_RD;
                        n_idx   = '0;
                    end
                end
            end
            S_RD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (out_load) begin
                    if (last_elem) begin
                        n_state = S_LOAD;
                        n_count = '0;
                        n_max   = {1'b1, {(LOGIT_W-1){1'b0}}};
                        n_ovf   = 1'b0;
                    end else begin
                        n_state = S_RD;
                        n_idx   = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_max    <= {1'b1, {(LOGIT_W-1){1'b0}}};
            r_ovf    <= 1'b0;
            r_sum    <= '0;
            r_rd_idx <= '0;
            r_rd_vld <= 1'b0;
            r_wr_idx <= '0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_max    <= n_max;
            r_ovf    <= n_ovf;
            r_sum    <= n_sum;
            r_rd_idx <= n_rd_idx;
            r_rd_vld <= n_rd_vld;
            r_wr_idx <= n_wr_idx;
            r_idx    <= n_idx;
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_idx  <= idx_wide[CLASS_W-1:0];
            r_out_prob <= div_prob;
            r_out_last <= last_elem;
            r_out_drop <= r_ovf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_class_index    = r_out_idx;
    assign o_probability    = r_out_prob;
    assign o_last_class     = r_out_last;
    assign o_dropped_logits = r_out_drop;

`ifndef NO_ASSERTIONS
    // the fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CLASSES))
        else $error("logit count beyond store depth");

    // a closing transfer starts the exp pass with at least one stored logit
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_last_logit |=> (r_state == S_EXP) && (r_count != '0))
        else $error("closing transfer did not start the exp pass");

    // the maximum contributes 1.0, so the divisor is never below it
    a_sum_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_sum >= SUM_W'(E_ONE)))
        else $error("exp sum below one at division");
`endif

endmodule

`default_nettype wire

FILE: design/smx_exp.sv
// Three-stage pipelined fixed-point exp(-u) unit, u in Q8.8, result in Q1.16.
`default_nettype none

module smx_exp (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [15:0]           i_u,
    output logic                       o_valid,
    output logic [smx_pkg::E_W-1:0]    o_e
);
    import smx_pkg::*;

    // stage 1: z = u * log2(e), rounded to Q.8
    logic [32:0]    prod1;
    logic [16:0]    z;
    logic           r1_valid;
    logic [8:0]     r1_k;
    logic [7:0]     r1_f;

    // stage 2: mantissa from table and linear correction
    logic [E_W-1:0] frac;
    logic [E_W-1:0] tab;
    logic [33:0]    prod2;
    logic           r2_valid;
    logic [8:0]     r2_k;
    logic [E_W-1:0] r2_m;

    // stage 3: shift by the integer part
    logic           r3_valid;
    logic [E_W-1:0] r3_e;

    assign prod1 = 33'(i_u) * 33'(LOG2E_Q16) + 33'(32768);
    assign z     = prod1[32:16];

    assign tab   = EXP2_TAB[r1_f[7:4]];
    assign frac  = E_ONE - 17'(r1_f[3:0]) * LN2_Q16;
    assign prod2 = 34'(tab) * 34'(frac) + 34'(32768);

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // data pipeline
    always_ff @(posedge i_clk) begin
        r1_k <= z[16:8];
        r1_f <= z[7:0];
        r2_k <= r1_k;
        r2_m <= prod2[32:16];
        if (r2_k[8:5] == 4'd0) begin
            r3_e <= r2_m >> r2_k[4:0];
        end else begin
            r3_e <= '0;
        end
    end

    assign o_valid = r3_valid;
    assign o_e     = r3_e;

endmodule

`default_nettype wire

FILE: design/smx_div.sv
// Restoring divider: rounded (e << 16) / sum, one quotient bit per cycle, saturated.
`default_nettype none

module smx_div #(
    parameter int SUM_W = 20
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [smx_pkg::E_W-1:0]    i_e,
    input  wire logic [SUM_W-1:0]           i_sum,
    output logic                            o_done,
    output logic [smx_pkg::PROB_W-1:0]      o_prob
);
    import smx_pkg::*;

    localparam int NUM_W = E_W + 17;

    logic [NUM_W-1:0]  num;
    logic [SUM_W:0]    trial;
    logic              fits;

    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_rem;
    logic [16:0]       r_low;
    logic [16:0]       r_quot;

    // numerator with half the divisor added for rounding
    assign num   = NUM_W'({i_e, 16'h0000}) + NUM_W'(i_sum >> 1);
    assign trial = {r_rem, r_low[16]};
    assign fits  = trial >= {1'b0, r_sum};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd16) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath: top bits of the numerator are already below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum  <= i_sum;
            r_rem  <= SUM_W'(num[NUM_W-1:17]);
            r_low  <= num[16:0];
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? SUM_W'(trial - {1'b0, r_sum}) : SUM_W'(trial);
            r_low  <= {r_low[15:0], 1'b0};
            r_quot <= {r_quot[15:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_prob = r_quot[16] ? {PROB_W{1'b1}} : r_quot[15:0];

endmodule

`default_nettype wire

FILE: tb/softmax_prob_checker.sv
// Checker for the softmax core: watches both channels, predicts probabilities and compares.
module softmax_prob_checker #(
    parameter int MAX_CLASSES = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_ready,
    input  wire logic [smx_pkg::LOGIT_W-1:0] i_logit,
    input  wire logic                        i_last_logit,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic [smx_pkg::CLASS_W-1:0] i_class_index,
    input  wire logic [smx_pkg::PROB_W-1:0]  i_probability,
    input  wire logic                        i_last_class,
    input  wire logic                        i_dropped_logits,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked
);
    import smx_pkg::*;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [PROB_W-1:0]  prob;
        logic               last;
        logic               dropped;
    } t_class_prob;

    // Predicted probabilities, oldest first
    t_class_prob prob_q[$];

    // Vector being collected
    logic signed [LOGIT_W-1:0] vec_logits[MAX_CLASSES];
    int                        vec_len;
    logic signed [LOGIT_W-1:0] vec_peak;
    logic                      vec_lost;

    int fails;
    int checked;

    // exp of a logit that sits gap below the peak, Q1.16
    function automatic logic [E_W-1:0] exp_below_peak(input logic [LOGIT_W-1:0] gap);
        logic [63:0] z;
        logic [63:0] k;
        logic [7:0]  f;
        logic [63:0] m;
        z = (64'(gap) * 64'(LOG2E_Q16) + 64'd32768) >> 16;
        k = z >> 8;
        f = z[7:0];
        m = (64'(EXP2_TAB[f[7:4]]) * (64'd65536 - 64'(f[3:0]) * 64'(LN2_Q16))
             + 64'd32768) >> 16;
        if (k >= 64'd32)
            return '0;
        return E_W'(m >> k);
    endfunction

    // Closing transfer: normalise the stored logits and queue one result per class
    function automatic void close_vector();
        logic [E_W-1:0] e_val[MAX_CLASSES];
        logic [31:0]    e_sum;
        logic [63:0]    quot;
        t_class_prob    res;
        e_sum = '0;
        for (int i = 0; i < vec_len; i++) begin
            e_val[i] = exp_below_peak(LOGIT_W'(vec_peak - vec_logits[i]));
            e_sum += 32'(e_val[i]);
        end
        for (int i = 0; i < vec_len; i++) begin
            quot = '0;
            if (e_sum != 0)
                quot = ((64'(e_val[i]) << 16) + 64'(e_sum >> 1)) / 64'(e_sum);
            if (quot > 64'd65535)
                quot = 64'd65535;
            res.cls     = CLASS_W'(i);
            res.prob    = PROB_W'(quot);
            res.last    = (i + 1 == vec_len);
            res.dropped = vec_lost;
            prob_q      = {prob_q, res};
        end
        vec_len  = 0;
        vec_peak = {1'b1, {(LOGIT_W-1){1'b0}}};
        vec_lost = 1'b0;
    endfunction

    initial begin
        vec_len  = 0;
        vec_peak = {1'b1, {(LOGIT_W-1){1'b0}}};
        vec_lost = 1'b0;
        fails    = 0;
        checked  = 0;
    end

    always @(posedge i_clk) begin
        t_class_prob want;
        if (i_rst_n) begin
            // Result transfer: compare with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (prob_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result class %0d prob %0d", $time,
                             i_class_index, i_probability);
                end else begin
                    want = prob_q.pop_front();
                    checked++;
                    if (i_class_index !== want.cls) begin
                        fails++;
                        $display("%0t: class_index expected %0d actual %0d", $time,
                                 want.cls, i_class_index);
                    end
                    if (i_probability !== want.prob) begin
                        fails++;
                        $display("%0t: probability (class %0d) expected %0d actual %0d",
                                 $time, want.cls, want.prob, i_probability);
                    end
                    if (i_last_class !== want.last) begin
                        fails++;
                        $display("%0t: last_class (class %0d) expected %0b actual %0b",
                                 $time, want.cls, want.last, i_last_class);
                    end
                    if (i_dropped_logits !== want.dropped) begin
                        fails++;
                        $display("%0t: dropped_logits (class %0d) expected %0b actual %0b",
                                 $time, want.cls, want.dropped, i_dropped_logits);
                    end
                end
            end
            // Logit transfer: store or drop, track the peak
            if (i_in_valid && i_in_ready) begin
                if (vec_len < MAX_CLASSES) begin
                    vec_logits[vec_len] = $signed(i_logit);
                    vec_len++;
                    if ($signed(i_logit) > vec_peak)
                        vec_peak = $signed(i_logit);
                end else begin
                    vec_lost = 1'b1;
                end
                if (i_last_logit)
                    close_vector();
            end
        end
        o_fail_count <= fails;
        o_pending    <= prob_q.size();
        o_checked    <= checked;
    end

endmodule

FILE: tb/tb_softmax_probabilities_core.sv
// Testbench top for the softmax core: clock, reset, logit stimulus, result stalls, verdict.
module tb_softmax_probabilities_core;
    import smx_pkg::*;

    localparam int MAX_CLASSES   = 8;
    localparam int TARGET_LOGITS = 250;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 200000;

    typedef enum int {RX_FREE, RX_CHOPPY, RX_STARVED} t_rx_mode;
    typedef enum int {SPREAD_WIDE, SPREAD_NARROW, SPREAD_TIES} t_spread;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [LOGIT_W-1:0] i_logit;
    logic               i_last_logit;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [CLASS_W-1:0] o_class_index;
    logic [PROB_W-1:0]  o_probability;
    logic               o_last_class;
    logic               o_dropped_logits;

    int fail_count;
    int pending;
    int checked;

    int  cycle_count = 0;
    int  logits_sent = 0;
    int  vectors_sent = 0;
    int  overfull_vectors = 0;
    int  burst_left = 0;
    logic hold_req = 1'b0;

    softmax_probabilities_core #(
        .MAX_CLASSES(MAX_CLASSES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_logit         (i_logit),
        .i_last_logit    (i_last_logit),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_class_index   (o_class_index),
        .o_probability   (o_probability),
        .o_last_class    (o_last_class),
        .o_dropped_logits(o_dropped_logits)
    );

    softmax_prob_checker #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_prob_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_logit         (i_logit),
        .i_last_logit    (i_last_logit),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_class_index   (o_class_index),
        .i_probability   (o_probability),
        .i_last_class    (o_last_class),
        .i_dropped_logits(o_dropped_logits),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("FAIL softmax_probabilities_core");
        $finish;
    end

    // Result side: random stall modes, plus one long hold-off on request
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        mode      = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    RX_FREE:    i_out_ready = 1'b1;
                    RX_CHOPPY:  i_out_ready = 1'($urandom_range(0, 1));
                    default:    i_out_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // One logit transfer; valid stays up between back-to-back transfers
    task automatic offer_logit(input logic [LOGIT_W-1:0] value, input logic last);
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_logit      = value;
        i_last_logit = last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        logits_sent++;
    endtask

    // Sender bursts: idle for a random gap once a burst is used up
    task automatic send_logit(input logic [LOGIT_W-1:0] value, input logic last);
        int gap;
        offer_logit(value, last);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(0, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // Lower valid and wait for every outstanding probability
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic send_vector(input logic [LOGIT_W-1:0] vals[$]);
        for (int i = 0; i < vals.size(); i++)
            send_logit(vals[i], i == vals.size() - 1);
        vectors_sent++;
        if (vals.size() > MAX_CLASSES)
            overfull_vectors++;
    endtask

    // Random logit, around a base for the narrow and tie spreads, clamped to the Q8.8 range
    function automatic logic [LOGIT_W-1:0] pick_logit(input t_spread spread, input int base);
        int v;
        case (spread)
            SPREAD_WIDE: begin
                case ($urandom_range(0, 9))
                    0:       v = -32768;
                    1:       v = 32767;
                    default: v = int'($urandom_range(0, 65535)) - 32768;
                endcase
            end
            SPREAD_NARROW: v = base + int'($urandom_range(0, 3071)) - 1536;
            default:       v = base + 256 * int'($urandom_range(0, 2));
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return LOGIT_W'(v);
    endfunction

    // Stimulus and verdict
    initial begin
        logic [LOGIT_W-1:0] vals[$];
        t_spread spread;
        int      base;
        int      len;
        int      rnd_vectors;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_logit      = '0;
        i_last_logit = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: single class saturates to 65535
        vals = {16'h7FFF};
        send_vector(vals);
        // Full-scale extremes, deepest exp gap
        vals = {16'h8000, 16'h7FFF};
        send_vector(vals);
        // Ties
        vals = {16'h0100, 16'h0100, 16'h0100};
        send_vector(vals);
        // Small values around zero
        vals = {16'h0000, 16'hFF00, 16'h0100, 16'hFFFF};
        send_vector(vals);
        // Store filled, then a closing logit past capacity that gets dropped
        vals = {16'h5555, 16'hAAAA, 16'h0001, 16'hFFFE,
                16'h00FF, 16'hFF01, 16'h0200, 16'h0180, 16'h7FFF};
        send_vector(vals);
        drain_results();

        // Random vectors
        rnd_vectors = 0;
        while (logits_sent < TARGET_LOGITS) begin
            if (rnd_vectors == 8)
                hold_req = 1'b1;
            if (rnd_vectors == 20)
                drain_results();
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: spread = SPREAD_WIDE;
                5, 6:          spread = SPREAD_TIES;
                default:       spread = SPREAD_NARROW;
            endcase
            base = int'($urandom_range(0, 65535)) - 32768;
            len  = ($urandom_range(0, 99) < 15) ? $urandom_range(MAX_CLASSES + 1, 12)
                                                : $urandom_range(1, MAX_CLASSES);
            vals.delete();
            for (int i = 0; i < len; i++)
                vals = {vals, pick_logit(spread, base)};
            send_vector(vals);
            rnd_vectors++;
        end

        drain_results();
        repeat (60) @(negedge i_clk);

        $display("Sent %0d logits in %0d vectors, %0d of them over capacity",
                 logits_sent, vectors_sent, overfull_vectors);
        $display("Checked %0d probabilities, %0d left unmatched", checked, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS softmax_probabilities_core");
        end else begin
            $display("FAIL softmax_probabilities_core");
        end
        $finish;
    end

endmodule

FILE: files.f
design/smx_pkg.sv
design/smx_exp.sv
design/smx_div.sv
design/softmax_probabilities_core.sv
tb/softmax_prob_checker.sv
tb/tb_softmax_probabilities_core.sv
